// File: rtl/core/bls_pkg.sv
package bls_pkg;

   localparam int DEPTH      = 16;
   localparam int ELEM_WIDTH = 32;

   localparam int ACTION_W = 2;
   localparam int VALUE_W  = 32;
   localparam int KIND_W   = 3;
   localparam int CAP_W    = 5;

   localparam int STORE_W = (ELEM_WIDTH < VALUE_W) ? ELEM_WIDTH : VALUE_W;
   localparam int CNT_W   = $clog2(DEPTH + 1);
   localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CMP_W   = (CNT_W > CAP_W) ? CNT_W : CAP_W;

   localparam logic [ACTION_W-1:0] ACT_PUSH  = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_POP   = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_PRINT = 2'd2;

   localparam logic [KIND_W-1:0] KIND_POPPED    = 3'd0;
   localparam logic [KIND_W-1:0] KIND_ENTRY     = 3'd1;
   localparam logic [KIND_W-1:0] KIND_EMPTY     = 3'd2;
   localparam logic [KIND_W-1:0] KIND_OVERFLOW  = 3'd3;
   localparam logic [KIND_W-1:0] KIND_UNDERFLOW = 3'd4;

   localparam logic [1:0] RD_TOP    = 2'd0;
   localparam logic [1:0] RD_BOTTOM = 2'd1;
   localparam logic [1:0] RD_WALK   = 2'd2;

   typedef struct packed {
      logic              push_en;
      logic              pop_en;
      logic              rd_en;
      logic [1:0]        rd_sel;
      logic              walk_load;
      logic              walk_inc;
      logic              emit;
      logic [KIND_W-1:0] kind;
      logic              last;
   } bls_cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
      logic fill_one;
      logic walk_last;
   } bls_status_type;

endpackage

// File: rtl/core/bls_ctrl.sv
module bls_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [bls_pkg::ACTION_W-1:0]  req_action,
   input  bls_pkg::bls_status_type       status,
   output logic                          busy,
   output bls_pkg::bls_cmd_type          cmd
);
   import bls_pkg::*;

   localparam logic ST_IDLE  = 1'b0;
   localparam logic ST_PRINT = 1'b1;

   logic state_ff;
   logic state_in;

   assign busy = (state_ff == ST_PRINT);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               unique case (req_action)
                  ACT_PUSH: begin
                     if (status.full) begin
                        cmd.emit = 1'b1;
                        cmd.kind = KIND_OVERFLOW;
                        cmd.last = 1'b1;
                     end else begin
                        cmd.push_en = 1'b1;
                     end
                  end
                  ACT_POP: begin
                     cmd.emit = 1'b1;
                     cmd.last = 1'b1;
                     if (status.empty) begin
                        cmd.kind = KIND_UNDERFLOW;
                     end else begin
                        cmd.kind   = KIND_POPPED;
                        cmd.pop_en = 1'b1;
                        cmd.rd_en  = 1'b1;
                        cmd.rd_sel = RD_TOP;
                     end
                  end
                  ACT_PRINT: begin
                     cmd.emit = 1'b1;
                     if (status.empty) begin
                        cmd.kind = KIND_EMPTY;
                        cmd.last = 1'b1;
                     end else begin
                        cmd.kind      = KIND_ENTRY;
                        cmd.rd_en     = 1'b1;
                        cmd.rd_sel    = RD_BOTTOM;
                        cmd.walk_load = 1'b1;
                        cmd.last      = status.fill_one;
                        if (!status.fill_one) begin
                           state_in = ST_PRINT;
                        end
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_PRINT: begin
            cmd.emit     = 1'b1;
            cmd.kind     = KIND_ENTRY;
            cmd.rd_en    = 1'b1;
            cmd.rd_sel   = RD_WALK;
            cmd.walk_inc = 1'b1;
            cmd.last     = status.walk_last;
            if (status.walk_last) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

`ifndef SYNTH
   a_print_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PRINT && status.walk_last) |=> (state_ff == ST_IDLE))
      else $error("print walk did not end on last entry");

   a_no_start_while_walk: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PRINT) |-> (!cmd.push_en && !cmd.pop_en))
      else $error("stack changed during print walk");

   a_one_op: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.push_en, cmd.pop_en, cmd.walk_load, cmd.walk_inc}))
      else $error("conflicting datapath commands");
`endif

endmodule

// File: rtl/core/bls_datapath.sv
module bls_datapath (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_wr_en,
   input  logic [bls_pkg::CAP_W-1:0]     csr_wr_data,
   input  logic [bls_pkg::VALUE_W-1:0]   req_item_value,
   input  bls_pkg::bls_cmd_type          cmd,
   output bls_pkg::bls_status_type       status,
   output logic                          rsp_valid,
   output logic [bls_pkg::KIND_W-1:0]    rsp_result_kind,
   output logic [bls_pkg::VALUE_W-1:0]   rsp_result_value,
   output logic                          rsp_last_of_run
);
   import bls_pkg::*;

   logic [STORE_W-1:0] stack_mem [DEPTH];
   logic [STORE_W-1:0] rd_data_ff;

   logic [CNT_W-1:0]   fill_count_ff;
   logic [CNT_W-1:0]   fill_count_in;
   logic [CAP_W-1:0]   capacity_ff;
   logic [ADDR_W-1:0]  walk_ff;
   logic [ADDR_W-1:0]  walk_in;
   logic [ADDR_W-1:0]  rd_addr;
   logic [CMP_W-1:0]   eff_cap;
   logic [CNT_W-1:0]   top_count;

   logic               rsp_valid_ff;
   logic [KIND_W-1:0]  rsp_kind_ff;
   logic               rsp_last_ff;
   logic               rsp_sel_ff;

   assign eff_cap = (CMP_W'(capacity_ff) > CMP_W'(DEPTH)) ? CMP_W'(DEPTH)
                                                           : CMP_W'(capacity_ff);
   assign top_count = fill_count_ff - CNT_W'(1);

   assign status.full      = (CMP_W'(fill_count_ff) >= eff_cap);
   assign status.empty     = (fill_count_ff == '0);
   assign status.fill_one  = (fill_count_ff == CNT_W'(1));
   assign status.walk_last = ((CNT_W'(walk_ff) + CNT_W'(1)) == fill_count_ff);

   always_comb begin
      unique case (cmd.rd_sel)
         RD_TOP:    rd_addr = top_count[ADDR_W-1:0];
         RD_BOTTOM: rd_addr = '0;
         RD_WALK:   rd_addr = walk_ff;
         default:   rd_addr = walk_ff;
      endcase
   end

   always_comb begin
      fill_count_in = fill_count_ff;
      if (csr_wr_en) begin
         fill_count_in = '0;
      end else if (cmd.push_en) begin
         fill_count_in = fill_count_ff + CNT_W'(1);
      end else if (cmd.pop_en) begin
         fill_count_in = top_count;
      end
   end

   always_comb begin
      walk_in = walk_ff;
      if (cmd.walk_load) begin
         walk_in = ADDR_W'(1);
      end else if (cmd.walk_inc) begin
         walk_in = walk_ff + ADDR_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.push_en) begin
         stack_mem[fill_count_ff[ADDR_W-1:0]] <= req_item_value[STORE_W-1:0];
      end
      if (cmd.rd_en) begin
         rd_data_ff <= stack_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_count_ff <= '0;
         capacity_ff   <= '0;
         walk_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         fill_count_ff <= fill_count_in;
         walk_ff       <= walk_in;
         rsp_valid_ff  <= cmd.emit;
         if (csr_wr_en) begin
            capacity_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_kind_ff <= cmd.kind;
      rsp_last_ff <= cmd.last;
      rsp_sel_ff  <= cmd.rd_en;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_kind  = rsp_kind_ff;
   assign rsp_last_of_run  = rsp_last_ff;
   assign rsp_result_value = rsp_sel_ff ? VALUE_W'(rd_data_ff) : '0;

`ifndef SYNTH
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_count_ff <= CNT_W'(DEPTH))
      else $error("fill count beyond depth");

   a_csr_clears: assert property (@(posedge clock) disable iff (reset)
      csr_wr_en |=> (fill_count_ff == '0))
      else $error("capacity write did not empty the stack");

   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      (cmd.push_en && !csr_wr_en) |=> (fill_count_ff == $past(fill_count_ff) + CNT_W'(1)))
      else $error("push did not advance fill count");
`endif

endmodule

// File: rtl/core/bounded_lifo_stack.sv
// Push: accepted with no result; overflow reported in the cycle after the transfer.
// Pop: result in the cycle after the transfer; the next command may follow at once.
// Print: one entry per cycle from the cycle after the transfer;
//   busy holds while the walk reads the remaining entries from the single-port store.
// Synchronous active-high reset empties the stack and sets capacity to 0.
// Results are strobed for one cycle; the receiver cannot stall them.
module bounded_lifo_stack (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [bls_pkg::ACTION_W-1:0]  req_action,
   input  logic [bls_pkg::VALUE_W-1:0]   req_item_value,
   input  logic                          csr_wr_en,
   input  logic [bls_pkg::CAP_W-1:0]     csr_wr_data,
   output logic                          rsp_valid,
   output logic [bls_pkg::KIND_W-1:0]    rsp_result_kind,
   output logic [bls_pkg::VALUE_W-1:0]   rsp_result_value,
   output logic                          rsp_last_of_run
);
   import bls_pkg::*;

   bls_cmd_type    cmd;
   bls_status_type status;

   bls_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_action (req_action),
      .status     (status),
      .busy       (busy),
      .cmd        (cmd)
   );

   bls_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .req_item_value   (req_item_value),
      .cmd              (cmd),
      .status           (status),
      .rsp_valid        (rsp_valid),
      .rsp_result_kind  (rsp_result_kind),
      .rsp_result_value (rsp_result_value),
      .rsp_last_of_run  (rsp_last_of_run)
   );

endmodule
